// ===== src/cbn_pkg.sv =====
`default_nettype none

package cbn_pkg;

    // field widths fixed by the item format
    localparam int COORD_W  = 16;
    localparam int SCORE_W  = 16;
    localparam int CORNER_W = 4 * COORD_W;
    localparam int THR_W    = 9;
    localparam int AREA_W   = 2 * COORD_W;
    localparam int UNION_W  = AREA_W + 1;
    localparam int PROD_W   = UNION_W + COORD_W;

    localparam logic [THR_W-1:0] THR_RESET = 9'd128;

    // sequencer states, one-hot
    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_SEL_RD   = 16'h0002,
        ST_SEL_CMP  = 16'h0004,
        ST_SEL_DONE = 16'h0008,
        ST_A_RD     = 16'h0010,
        ST_A_LD     = 16'h0020,
        ST_A_MUL    = 16'h0040,
        ST_EMIT     = 16'h0080,
        ST_SUP_RD   = 16'h0100,
        ST_SUP_CHK  = 16'h0200,
        ST_I_SPAN   = 16'h0400,
        ST_I_M1     = 16'h0800,
        ST_I_M2     = 16'h1000,
        ST_I_M3     = 16'h2000,
        ST_I_CMP    = 16'h4000,
        ST_FLUSH    = 16'h8000
    } state_t;

    // width or height, zero when inverted
    function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                                input logic [COORD_W-1:0] hi);
        span = (hi >= lo) ? hi - lo : '0;
    endfunction

    function automatic logic [COORD_W-1:0] max16(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
        max16 = (a > b) ? a : b;
    endfunction

    function automatic logic [COORD_W-1:0] min16(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
        min16 = (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== src/classwise_box_nms.sv =====
// loading: the input stays ready after each non-final box, so boxes may arrive back to back
// suppression after the final box: rank selection scans the store for the best-ranked
// unvisited box; each unsuppressed pick is passed on and then compared with every live
// same-class box (IoU only when they overlap); a flush ends the batch; output stalls hold it
// results leave in rank order through one output register
// reset (aresetn low, synchronous) empties the batch and sets the threshold to 0.5
`default_nettype none

module classwise_box_nms #(
    parameter int MAX_BOXES  = 64,
    parameter int CLASS_BITS = 7
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [cbn_pkg::THR_W-1:0] cfg_wr_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // box_left, box_top, box_right, box_bottom, score, class_index
    input  wire logic [((5*16+CLASS_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // kept_left, kept_top, kept_right, kept_bottom, kept_score, kept_class
    output logic [((5*16+CLASS_BITS+7)/8)*8-1:0] m_tdata,
    output logic                      m_tlast,
    // overflowed
    output logic [0:0]                m_tuser
);
    import cbn_pkg::*;

    localparam int IDX_W   = $clog2(MAX_BOXES);
    localparam int CNT_W   = $clog2(MAX_BOXES + 1);
    localparam int SC_W    = SCORE_W + CLASS_BITS;
    localparam int PAY_W   = CORNER_W + SC_W;
    localparam int TDATA_W = ((5*16+CLASS_BITS+7)/8)*8;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [THR_W-1:0]      thr_reg;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic [SC_W-1:0]       best_sc_reg, best_sc_next;
    logic                  found_reg, found_next;
    logic [MAX_BOXES-1:0]  proc_reg, proc_next;
    logic [MAX_BOXES-1:0]  supp_reg, supp_next;
    logic [CORNER_W-1:0]   a_corner_reg, a_corner_next;
    logic [SC_W-1:0]       a_sc_reg, a_sc_next;
    logic [AREA_W-1:0]     area_a_reg, area_a_next;
    logic [CORNER_W-1:0]   b_corner_reg, b_corner_next;
    logic [COORD_W-1:0]    iw_reg, iw_next, ih_reg, ih_next;
    logic [COORD_W-1:0]    bw_reg, bw_next, bh_reg, bh_next;
    logic [AREA_W-1:0]     inter_reg, inter_next;
    logic [AREA_W-1:0]     area_b_reg, area_b_next;
    logic [UNION_W-1:0]    uni_reg, uni_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [PAY_W-1:0]      pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PAY_W-1:0]      out_reg, out_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic [CORNER_W-1:0]   rd_corner;
    logic [SC_W-1:0]       rd_sc;
    logic                  wr_en;
    logic                  in_acc;
    logic                  out_free;
    logic                  last_j;
    logic [UNION_W-1:0]    mul_a;
    logic [COORD_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_p;

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign wr_en    = in_acc && (count_reg < CNT_MAX);
    assign out_free = !out_valid_reg || m_tready;
    assign last_j   = (CNT_W'(j_reg + 1'b1) == count_reg);

    cbn_box_store #(
        .DEPTH (MAX_BOXES),
        .SC_W  (SC_W)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (count_reg[IDX_W-1:0]),
        .wr_corner (s_tdata[CORNER_W-1:0]),
        .wr_sc     (s_tdata[PAY_W-1:CORNER_W]),
        .rd_addr   (j_reg[IDX_W-1:0]),
        .rd_corner (rd_corner),
        .rd_sc     (rd_sc)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_A_MUL: begin
                mul_a = UNION_W'(span(a_corner_reg[15:0], a_corner_reg[47:32]));
                mul_b = span(a_corner_reg[31:16], a_corner_reg[63:48]);
            end
            ST_I_M1: begin
                mul_a = UNION_W'(iw_reg);
                mul_b = ih_reg;
            end
            ST_I_M2: begin
                mul_a = UNION_W'(bw_reg);
                mul_b = bh_reg;
            end
            ST_I_CMP: begin
                mul_a = uni_reg;
                mul_b = COORD_W'(thr_reg);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // sequencer
    always_comb begin
        logic [COORD_W-1:0] il, ir, it, ib;
        logic [UNION_W-1:0] sum;
        logic               better;
        il = max16(a_corner_reg[15:0],  b_corner_reg[15:0]);
        it = max16(a_corner_reg[31:16], b_corner_reg[31:16]);
        ir = min16(a_corner_reg[47:32], b_corner_reg[47:32]);
        ib = min16(a_corner_reg[63:48], b_corner_reg[63:48]);
        sum = UNION_W'(area_a_reg) + UNION_W'(area_b_reg);
        better = (rd_sc[SC_W-1:SCORE_W] < best_sc_reg[SC_W-1:SCORE_W]) ||
                 ((rd_sc[SC_W-1:SCORE_W] == best_sc_reg[SC_W-1:SCORE_W]) &&
                  (rd_sc[SCORE_W-1:0] > best_sc_reg[SCORE_W-1:0]));

        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        j_next          = j_reg;
        best_next       = best_reg;
        best_sc_next    = best_sc_reg;
        found_next      = found_reg;
        proc_next       = proc_reg;
        supp_next       = supp_reg;
        a_corner_next   = a_corner_reg;
        a_sc_next       = a_sc_reg;
        area_a_next     = area_a_reg;
        b_corner_next   = b_corner_reg;
        iw_next         = iw_reg;
        ih_next         = ih_reg;
        bw_next         = bw_reg;
        bh_next         = bh_reg;
        inter_next      = inter_reg;
        area_b_next     = area_b_reg;
        uni_next        = uni_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;

        // output register drains
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (count_reg < CNT_MAX) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        j_next     = '0;
                        found_next = 1'b0;
                        state_next = ST_SEL_RD;
                    end
                end
            end
            ST_SEL_RD: begin
                state_next = ST_SEL_CMP;
            end
            // find the best-ranked box not yet visited
            ST_SEL_CMP: begin
                if (!proc_reg[j_reg[IDX_W-1:0]] && (!found_reg || better)) begin
                    best_next    = j_reg[IDX_W-1:0];
                    best_sc_next = rd_sc;
                    found_next   = 1'b1;
                end
                if (last_j) begin
                    state_next = ST_SEL_DONE;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SEL_RD;
                end
            end
            ST_SEL_DONE: begin
                if (!found_reg) begin
                    state_next = ST_FLUSH;
                end else begin
                    proc_next[best_reg] = 1'b1;
                    found_next          = 1'b0;
                    if (supp_reg[best_reg]) begin
                        j_next     = '0;
                        state_next = ST_SEL_RD;
                    end else begin
                        j_next     = CNT_W'(best_reg);
                        state_next = ST_A_RD;
                    end
                end
            end
            ST_A_RD: begin
                state_next = ST_A_LD;
            end
            ST_A_LD: begin
                a_corner_next = rd_corner;
                a_sc_next     = rd_sc;
                state_next    = ST_A_MUL;
            end
            ST_A_MUL: begin
                area_a_next = mul_p[AREA_W-1:0];
                state_next  = ST_EMIT;
            end
            // hand the previous survivor on, hold this one back
            ST_EMIT: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_last_next  = 1'b0;
                        out_ovf_next   = ovf_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = {a_sc_reg, a_corner_reg};
                    j_next          = '0;
                    state_next      = ST_SUP_RD;
                end
            end
            ST_SUP_RD: begin
                state_next = ST_SUP_CHK;
            end
            // later boxes of the same class still alive
            ST_SUP_CHK: begin
                if (!proc_reg[j_reg[IDX_W-1:0]] && !supp_reg[j_reg[IDX_W-1:0]] &&
                    (rd_sc[SC_W-1:SCORE_W] == a_sc_reg[SC_W-1:SCORE_W])) begin
                    b_corner_next = rd_corner;
                    state_next    = ST_I_SPAN;
                end else if (last_j) begin
                    j_next     = '0;
                    state_next = ST_SEL_RD;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SUP_RD;
                end
            end
            ST_I_SPAN: begin
                iw_next = ir - il;
                ih_next = ib - it;
                bw_next = span(b_corner_reg[15:0],  b_corner_reg[47:32]);
                bh_next = span(b_corner_reg[31:16], b_corner_reg[63:48]);
                if ((it > ib) || (il > ir)) begin
                    if (last_j) begin
                        j_next     = '0;
                        state_next = ST_SEL_RD;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_SUP_RD;
                    end
                end else begin
                    state_next = ST_I_M1;
                end
            end
            ST_I_M1: begin
                inter_next = mul_p[AREA_W-1:0];
                state_next = ST_I_M2;
            end
            ST_I_M2: begin
                area_b_next = mul_p[AREA_W-1:0];
                state_next  = ST_I_M3;
            end
            ST_I_M3: begin
                uni_next   = (sum >= UNION_W'(inter_reg)) ? sum - UNION_W'(inter_reg) : '0;
                state_next = ST_I_CMP;
            end
            // inter * 256 against threshold * union
            ST_I_CMP: begin
                if (mul_p < PROD_W'({inter_reg, 8'h00})) begin
                    supp_next[j_reg[IDX_W-1:0]] = 1'b1;
                end
                if (last_j) begin
                    j_next     = '0;
                    state_next = ST_SEL_RD;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SUP_RD;
                end
            end
            // last survivor carries the end mark, then the batch empties
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_last_next  = 1'b1;
                        out_ovf_next   = ovf_reg;
                    end
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    proc_next       = '0;
                    supp_next       = '0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            thr_reg        <= THR_RESET;
            found_reg      <= 1'b0;
            proc_reg       <= '0;
            supp_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            found_reg      <= found_next;
            proc_reg       <= proc_next;
            supp_reg       <= supp_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        j_reg        <= j_next;
        best_reg     <= best_next;
        best_sc_reg  <= best_sc_next;
        a_corner_reg <= a_corner_next;
        a_sc_reg     <= a_sc_next;
        area_a_reg   <= area_a_next;
        b_corner_reg <= b_corner_next;
        iw_reg       <= iw_next;
        ih_reg       <= ih_next;
        bw_reg       <= bw_next;
        bh_reg       <= bh_next;
        inter_reg    <= inter_next;
        area_b_reg   <= area_b_next;
        uni_reg      <= uni_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

`default_nettype wire

// ===== src/cbn_box_store.sv =====
`default_nettype none

module cbn_box_store #(
    parameter int DEPTH   = 64,
    parameter int SC_W    = 23
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire logic [cbn_pkg::CORNER_W-1:0] wr_corner,
    input  wire logic [SC_W-1:0]              wr_sc,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic      [cbn_pkg::CORNER_W-1:0] rd_corner,
    output logic      [SC_W-1:0]              rd_sc
);
    import cbn_pkg::*;

    logic [CORNER_W-1:0] corner_mem [DEPTH];
    logic [SC_W-1:0]     sc_mem     [DEPTH];

    // one write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            corner_mem[wr_addr] <= wr_corner;
            sc_mem[wr_addr]     <= wr_sc;
        end
        rd_corner <= corner_mem[rd_addr];
        rd_sc     <= sc_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/cbn_checker.sv =====
`default_nettype none

module cbn_checker #(
    parameter int TDATA_W = 88
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               s_tlast,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic               m_tlast
);

    // reset empties the output
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    // a final box starts suppression, input closes
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open right after final box");

    // input only closes after a final box
    a_close_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tlast))
        else $error("input closed without a final box");

endmodule

bind classwise_box_nms cbn_checker #(
    .TDATA_W ($bits(m_tdata))
) u_cbn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import cbn_pkg::*;

    localparam int CAP    = 64;
    localparam int CBITS  = 7;
    localparam int DATA_W = ((5*16+CBITS+7)/8)*8;

    typedef struct {
        logic [COORD_W-1:0] left, top, right, bottom;
        logic [SCORE_W-1:0] score;
        logic [CBITS-1:0]   cls;
        logic               last;
    } box_t;

    typedef struct {
        logic [COORD_W-1:0] left, top, right, bottom;
        logic [SCORE_W-1:0] score;
        logic [CBITS-1:0]   cls;
        logic               last;
        logic               ovf;
    } kept_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [THR_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;
    logic                m_tlast;
    logic [0:0]          m_tuser;

    classwise_box_nms #(.MAX_BOXES(CAP), .CLASS_BITS(CBITS)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always #1 aclk = ~aclk;

    // predictor state
    box_t             batch_store[CAP];
    logic             sup_mark[CAP];
    int               batch_count = 0;
    logic             batch_ovf = 1'b0;
    logic [THR_W-1:0] thr_model = THR_RESET;

    box_t  box_q[$];
    kept_t kept_q[$];
    box_t  cur_box;
    int    mismatches = 0;

    function automatic longint unsigned span_of(logic [15:0] lo, logic [15:0] hi);
        return (hi >= lo) ? longint'(hi - lo) : 0;
    endfunction

    // iou above threshold, cross-multiplied
    function automatic bit too_close(box_t a, box_t b);
        longint unsigned l, r, t, bt, inter, sum, uni;
        l  = (a.left > b.left) ? a.left : b.left;
        r  = (a.right < b.right) ? a.right : b.right;
        t  = (a.top > b.top) ? a.top : b.top;
        bt = (a.bottom < b.bottom) ? a.bottom : b.bottom;
        if (t > bt || l > r) return 0;
        inter = (r - l) * (bt - t);
        sum = span_of(a.left, a.right) * span_of(a.top, a.bottom)
            + span_of(b.left, b.right) * span_of(b.top, b.bottom);
        uni = (sum >= inter) ? sum - inter : 0;
        return (inter * 256) > (longint'(thr_model) * uni);
    endfunction

    function automatic bit ranked_ahead(int a, int b);
        if (batch_store[a].cls != batch_store[b].cls)
            return batch_store[a].cls < batch_store[b].cls;
        if (batch_store[a].score != batch_store[b].score)
            return batch_store[a].score > batch_store[b].score;
        return a < b;
    endfunction

    // store one box; on the final item rank, suppress and queue the survivors
    task automatic nms_predict(box_t bx);
        int    order[CAP];
        int    i, j, v, a, b, lastk;
        kept_t k;
        if (batch_count < CAP) begin
            batch_store[batch_count] = bx;
            sup_mark[batch_count] = 1'b0;
            batch_count++;
        end else begin
            batch_ovf = 1'b1;
        end
        if (!bx.last) return;
        for (i = 0; i < batch_count; i++) begin
            v = i;
            j = i;
            while (j > 0 && ranked_ahead(v, order[j-1])) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
        end
        for (i = 0; i < batch_count; i++) begin
            a = order[i];
            if (!sup_mark[a]) begin
                for (j = i + 1; j < batch_count; j++) begin
                    b = order[j];
                    if (batch_store[b].cls != batch_store[a].cls) break;
                    if (!sup_mark[b] && too_close(batch_store[a], batch_store[b]))
                        sup_mark[b] = 1'b1;
                end
            end
        end
        lastk = -1;
        for (i = 0; i < batch_count; i++) begin
            a = order[i];
            if (!sup_mark[a]) begin
                k.left = batch_store[a].left;   k.top = batch_store[a].top;
                k.right = batch_store[a].right; k.bottom = batch_store[a].bottom;
                k.score = batch_store[a].score; k.cls = batch_store[a].cls;
                k.last = 1'b0;
                k.ovf = batch_ovf;
                kept_q = {kept_q, k};
                lastk = kept_q.size() - 1;
            end
        end
        if (lastk >= 0) kept_q[lastk].last = 1'b1;
        batch_count = 0;
        batch_ovf = 1'b0;
        for (i = 0; i < CAP; i++) sup_mark[i] = 1'b0;
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // sender: bursts with random gaps
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) nms_predict(cur_box);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (box_q.size() > 0) begin
                    cur_box = box_q.pop_front();
                    s_tdata <= {1'b0, cur_box.cls, cur_box.score, cur_box.bottom,
                                cur_box.right, cur_box.top, cur_box.left};
                    s_tlast <= cur_box.last;
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern, plus one long hold once a big batch is out
    int  cyc = 0;
    int  hold_left = 0;
    bit  held_once = 0;
    always @(posedge aclk) begin
        cyc++;
        if (!held_once && kept_q.size() > 20) begin
            held_once = 1;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (cyc[8:7] == 2'd0) begin
            m_tready <= 1'b1;
        end else if (cyc[8:7] == 2'd1) begin
            m_tready <= cyc[2] | cyc[0];
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge aclk) begin
        kept_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (kept_q.size() == 0) begin
                report("unexpected item", m_tdata[63:0], 0);
            end else begin
                e = kept_q.pop_front();
                if (m_tdata[15:0] != e.left)    report("left", m_tdata[15:0], e.left);
                if (m_tdata[31:16] != e.top)    report("top", m_tdata[31:16], e.top);
                if (m_tdata[47:32] != e.right)  report("right", m_tdata[47:32], e.right);
                if (m_tdata[63:48] != e.bottom) report("bottom", m_tdata[63:48], e.bottom);
                if (m_tdata[79:64] != e.score)  report("score", m_tdata[79:64], e.score);
                if (m_tdata[86:80] != e.cls)    report("class", m_tdata[86:80], e.cls);
                if (m_tlast != e.last)          report("last", m_tlast, e.last);
                if (m_tuser[0] != e.ovf)        report("overflow", m_tuser[0], e.ovf);
            end
        end
    end

    task automatic add_box(int l, int t, int r, int b, int s, int c, bit last);
        box_t bx;
        bx.left = COORD_W'(l); bx.top = COORD_W'(t);
        bx.right = COORD_W'(r); bx.bottom = COORD_W'(b);
        bx.score = SCORE_W'(s); bx.cls = CBITS'(c); bx.last = last;
        box_q = {box_q, bx};
    endtask

    // clustered batch (a few classes, jitter around one centre) or random noise boxes
    task automatic add_batch(int n);
        int i, cx, cy, w, h, l, t;
        int cls_pool[3];
        bit noise;
        noise = ($urandom_range(0, 3) == 0);
        for (i = 0; i < 3; i++) cls_pool[i] = $urandom_range(0, 127);
        cx = $urandom_range(0, 60000);
        cy = $urandom_range(0, 60000);
        for (i = 0; i < n; i++) begin
            if (noise) begin
                add_box($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 127), i == n - 1);
            end else begin
                w = $urandom_range(1, 2000);
                h = $urandom_range(1, 2000);
                l = cx + $urandom_range(0, 600);
                t = cy + $urandom_range(0, 600);
                add_box(l, t, (l + w > 65535) ? 65535 : l + w,
                        (t + h > 65535) ? 65535 : t + h,
                        ($urandom_range(0, 4) == 0) ? 16'h8000 : $urandom_range(0, 65535),
                        cls_pool[$urandom_range(0, 2)], i == n - 1);
            end
        end
    endtask

    task automatic wait_idle();
        while (box_q.size() > 0 || s_tvalid || kept_q.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        thr_model = v;
    endtask

    initial begin
        logic [THR_W-1:0] thr_list[7];
        int p, i;
        thr_list = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd200, 9'd77, 9'd128};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset threshold, directed corner cases
        add_box(100, 100, 500, 500, 1000, 5, 0);
        add_box(100, 100, 500, 500, 1000, 5, 0);
        add_box(120, 110, 520, 490, 900, 5, 0);
        add_box(5000, 5000, 5400, 5400, 800, 5, 0);
        add_box(700, 700, 600, 600, 950, 5, 0);
        add_box(300, 300, 300, 300, 990, 5, 0);
        add_box(0, 0, 65535, 65535, 65535, 127, 0);
        add_box(0, 0, 65535, 65535, 0, 127, 0);
        add_box(65535, 65535, 65535, 65535, 0, 0, 0);
        add_box(0, 0, 0, 0, 65535, 0, 1);
        add_box(10, 20, 30, 40, 50, 3, 1);
        wait_idle();

        for (p = 0; p < 7; p++) begin
            write_threshold(p == 6 ? THR_W'($urandom_range(0, 511)) : thr_list[p]);
            if (p == 0) begin
                // store full: one box beyond capacity, the final one dropped
                for (i = 0; i < CAP + 1; i++)
                    add_box($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 3), i == CAP);
            end
            for (i = 0; i < 3; i++) add_batch($urandom_range(1, 10));
            wait_idle();
        end

        write_threshold(THR_RESET);
        for (i = 0; i < 3; i++) add_batch($urandom_range(1, 10));
        wait_idle();
        repeat (50) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== classwise_box_nms.f =====
src/cbn_pkg.sv
src/cbn_box_store.sv
src/classwise_box_nms.sv
src/cbn_checker.sv
test/tb_top.sv
